>>> rtl/core/soc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package soc_pkg;

    localparam int DEF_MAX_PATTERN = 8;
    localparam int LINE_W          = 20;
    localparam int COUNT_W         = 24;
    localparam int LEN_W           = 4;
    localparam int CFG_DATA_W      = 64;

    localparam logic [7:0]         NEWLINE_BYTE = 8'h0A;
    localparam logic [LINE_W-1:0]  LINE_MAX     = {LINE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

    typedef enum logic [0:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       file_end;
    } soc_in_t;

    typedef struct packed {
        logic [LINE_W-1:0]  line_number;
        logic               line_has_match;
        logic [COUNT_W-1:0] match_count;
        logic               file_done;
    } soc_out_t;

    typedef struct packed {
        logic       advance;
        logic       flush;
    } soc_cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/soc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module soc_cell
    import soc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire soc_cell_ctrl_t ctrl,
    input  wire logic [7:0]     byte_in,
    input  wire logic           valid_in,
    input  wire logic           in_window,
    input  wire logic [7:0]     expected,
    output logic [7:0]          byte_out,
    output logic                valid_out,
    output logic                hit
);

    logic [7:0] byte_reg;
    logic       valid_reg;
    logic       valid_next;

    // The cell compares the byte it is about to hold, so a match is seen on
    // the beat that carries its last byte.
    assign hit        = !in_window || (valid_in && (byte_in == expected));
    assign valid_next = ctrl.flush ? 1'b0 : valid_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/soc_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module soc_tracker
    import soc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire soc_in_t beat_in,
    input  wire logic    match,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output soc_out_t     out_data
);

    logic [LINE_W-1:0]  line_reg;
    logic [LINE_W-1:0]  line_next;
    logic               hit_reg;
    logic               hit_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_now;
    logic               hit_now;
    logic               emit;
    soc_out_t           result;

    soc_out_t           slot0_reg;
    soc_out_t           slot0_next;
    soc_out_t           slot1_reg;
    soc_out_t           slot1_next;
    logic [1:0]         fill_reg;
    logic [1:0]         fill_next;
    logic               push;
    logic               pop;

    always_comb
    begin
        count_now = (match && (count_reg != COUNT_MAX)) ? count_reg + COUNT_W'(1) : count_reg;
        hit_now   = hit_reg | match;
        emit      = (beat_in.text_byte == NEWLINE_BYTE) || beat_in.file_end;

        result.line_number    = line_reg;
        result.line_has_match = hit_now;
        result.match_count    = count_now;
        result.file_done      = beat_in.file_end;

        line_next  = line_reg;
        hit_next   = hit_now;
        count_next = count_now;
        if (beat_in.file_end)
        begin
            line_next  = LINE_W'(1);
            hit_next   = 1'b0;
            count_next = '0;
        end
        else if (emit)
        begin
            if (line_reg != LINE_MAX)
            begin
                line_next = line_reg + LINE_W'(1);
            end
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= LINE_W'(1);
            hit_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            line_reg  <= line_next;
            hit_reg   <= hit_next;
            count_reg <= count_next;
        end
    end

    // Two-entry result queue so a new beat is taken while a result waits.
    assign push      = accept && emit;
    assign pop       = out_valid && out_ready;
    assign out_valid = (fill_reg != 2'd0);
    assign room      = (fill_reg != 2'd2);
    assign out_data  = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        fill_next  = fill_reg;
        case (fill_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = result;
                    fill_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    slot0_next = result;
                end
                else if (push)
                begin
                    slot1_next = result;
                    fill_next  = 2'd2;
                end
                else if (pop)
                begin
                    fill_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    fill_next  = 2'd1;
                end
            end
            default:
            begin
                fill_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/substring_occurrence_counter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Counts non-overlapping occurrences of a configured word of 1 to MAX_PATTERN
// bytes in a byte stream, one text byte per beat, and returns one result beat
// at each newline and at the beat marked as the file's last. The unit takes one
// byte every clock cycle: the last MAX_PATTERN bytes sit in a row of cells that
// shift once per accepted beat and each compare their byte in the same cycle,
// so a result is registered into a two-entry queue as its byte is accepted. Input
// stalls only when both queue entries are held by the receiver. Write the
// pattern registers while no file is in progress; lengths above MAX_PATTERN
// act as MAX_PATTERN and a length of zero never matches.
module substring_occurrence_counter_unit
    import soc_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire soc_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output soc_out_t                   out_data
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CFG_DATA_W-1:0] pattern_bytes_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    logic [LEN_W-1:0]      eff_len;
    logic [7:0]            pat_byte [MAX_PATTERN];

    logic                  accept;
    logic                  match;
    logic                  room;
    soc_cell_ctrl_t        cell_ctrl;

    logic [7:0]            chain_byte  [MAX_PATTERN+1];
    logic                  chain_valid [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] cell_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            pattern_length_reg <= pattern_length_reg;
            endcase
        end
    end

    assign eff_len = (pattern_length_reg > LEN_W'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : pattern_length_reg;

    assign accept   = in_valid && in_ready;
    assign in_ready = room;
    assign match    = (eff_len != '0) && (&cell_hit);

    assign cell_ctrl.advance = accept;
    assign cell_ctrl.flush   = match || in_data.file_end;

    assign chain_byte[0]  = in_data.text_byte;
    assign chain_valid[0] = 1'b1;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            logic [LEN_W-1:0] sel;
            logic             in_win;

            assign pat_byte[k] = pattern_bytes_reg[8*k +: 8];
            assign in_win      = LEN_W'(k) < eff_len;
            assign sel         = eff_len - LEN_W'(1) - LEN_W'(k);

            soc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .byte_in   (chain_byte[k]),
                .valid_in  (chain_valid[k]),
                .in_window (in_win),
                .expected  (pat_byte[sel[IDX_W-1:0]]),
                .byte_out  (chain_byte[k+1]),
                .valid_out (chain_valid[k+1]),
                .hit       (cell_hit[k])
            );
        end
    endgenerate

    soc_tracker u_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .beat_in   (in_data),
        .match     (match),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
